@@ hdl/svfm_pkg.sv @@
package svfm_pkg;

   // Sizes of the filter.
   localparam int CHANNELS      = 8;
   localparam int CHAN_BITS     = 3;
   localparam int CHAN_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_BITS   = 24;
   localparam int STATE_BITS    = 32;
   localparam int COEF_FRAC     = 16;
   localparam int MODE_BITS     = 3;
   localparam int FREQ_BITS     = 15;
   localparam int DAMP_BITS     = 19;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 19;

   // Product widths and the common width of the integrator sums.
   localparam int DAMP_PROD_BITS = STATE_BITS + DAMP_BITS;
   localparam int FREQ_PROD_BITS = STATE_BITS + FREQ_BITS + 1;
   localparam int SUM_BITS       = DAMP_PROD_BITS + 1;
   localparam int SEL_BITS       = STATE_BITS + 1;

   // Register indexes.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FREQ = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DAMP = 2'd2;

   // Output select codes.
   localparam logic [MODE_BITS-1:0] MODE_LOW   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_HIGH  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_BAND  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_NOTCH = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_PEAK  = 3'd4;

   // Register reset values.
   localparam logic [MODE_BITS-1:0]        MODE_RESET = MODE_LOW;
   localparam logic [FREQ_BITS-1:0]        FREQ_RESET = 15'd12864;
   localparam logic signed [DAMP_BITS-1:0] DAMP_RESET = 19'sd94000;

   typedef struct packed {
      logic [MODE_BITS-1:0]        mode;
      logic [FREQ_BITS-1:0]        freq;
      logic signed [DAMP_BITS-1:0] damp;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_BAND,
      ST_UPD_LN,
      ST_CALC_HIGH,
      ST_MUL_HIGH,
      ST_UPD_BAND,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_BAND,
      OP_UPD_LN,
      OP_CALC_HIGH,
      OP_MUL_HIGH,
      OP_UPD_BAND,
      OP_FINISH
   } op_type;

   // Clamp a wide sum to the signed integrator range.
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] v);
      logic [SUM_BITS-STATE_BITS:0] top;
      logic signed [STATE_BITS-1:0] r;
      top = v[SUM_BITS-1:STATE_BITS-1];
      if ((&top) || !(|top)) begin
         r = v[STATE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   // Halve (floor) and clamp to the signed sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] half_sat_sample(
      input logic signed [SEL_BITS-1:0] v);
      logic signed [SEL_BITS-2:0] h;
      logic [SEL_BITS-1-SAMPLE_BITS:0] top;
      logic signed [SAMPLE_BITS-1:0] r;
      h = v[SEL_BITS-1:1];
      top = h[SEL_BITS-2:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         r = h[SAMPLE_BITS-1:0];
      end else if (h[SEL_BITS-2]) begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

@@ hdl/svfm_csr.sv @@
module svfm_csr
   import svfm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE: cfg_in.mode = csr_wdata[MODE_BITS-1:0];
            CSR_FREQ: cfg_in.freq = csr_wdata[FREQ_BITS-1:0];
            CSR_DAMP: cfg_in.damp = csr_wdata[DAMP_BITS-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= MODE_RESET;
         cfg_ff.freq <= FREQ_RESET;
         cfg_ff.damp <= DAMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/svfm_ctrl.sv @@
module svfm_ctrl
   import svfm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   req_valid,
   output logic   req_stall,
   output logic   rsp_valid,
   input  logic   rsp_stall,
   output op_type op
);

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_BAND;
               pass_in  = 1'b0;
            end
         end
         ST_MUL_BAND:  state_in = ST_UPD_LN;
         ST_UPD_LN:    state_in = ST_CALC_HIGH;
         ST_CALC_HIGH: state_in = ST_MUL_HIGH;
         ST_MUL_HIGH:  state_in = ST_UPD_BAND;
         ST_UPD_BAND: begin
            pass_in  = 1'b1;
            state_in = pass_ff ? ST_FINISH : ST_MUL_BAND;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      op        = OP_NONE;
      unique case (state_ff)
         ST_IDLE:      op = req_valid ? OP_LOAD : OP_NONE;
         ST_MUL_BAND:  op = OP_MUL_BAND;
         ST_UPD_LN:    op = OP_UPD_LN;
         ST_CALC_HIGH: op = OP_CALC_HIGH;
         ST_MUL_HIGH:  op = OP_MUL_HIGH;
         ST_UPD_BAND:  op = OP_UPD_BAND;
         ST_FINISH:    op = out_free ? OP_FINISH : OP_NONE;
         default:      op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op == OP_FINISH) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/svfm_dp.sv @@
module svfm_dp
   import svfm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  op_type                        op,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic [CHAN_BITS-1:0]          req_chan,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [CHAN_BITS-1:0]          rsp_chan_out
);

   // Per-channel integrators.
   logic signed [STATE_BITS-1:0] low_mem_ff  [CHANNELS];
   logic signed [STATE_BITS-1:0] band_mem_ff [CHANNELS];

   // Working registers for the item in flight.
   logic signed [SAMPLE_BITS-1:0]    x_ff;
   logic [CHAN_BITS-1:0]             chan_ff;
   logic [CHAN_IDX_BITS-1:0]         idx_ff;
   logic                             chan_ok_ff;
   logic signed [STATE_BITS-1:0]     low_ff, band_ff, notch_ff, high_ff;
   logic signed [DAMP_PROD_BITS-1:0] pq_ff;
   logic signed [FREQ_PROD_BITS-1:0] pf_ff;
   logic signed [SAMPLE_BITS-1:0]    out_sample_ff;
   logic [CHAN_BITS-1:0]             out_chan_ff;

   logic [CHAN_IDX_BITS-1:0]         req_idx;
   logic                             req_ok;
   logic signed [FREQ_BITS:0]        freq_s;
   logic signed [STATE_BITS-1:0]     freq_operand;
   logic signed [SUM_BITS-1:0]       notch_sum, low_sum, band_sum, high_sum;
   logic signed [SEL_BITS-1:0]       sel;
   logic signed [SAMPLE_BITS-1:0]    out_value;

   assign req_idx = CHAN_IDX_BITS'(req_chan);
   assign req_ok  = (32'(req_chan) < CHANNELS);
   assign freq_s  = $signed({1'b0, cfg.freq});

   // The frequency multiplier sees band in the first multiply, high in the second.
   assign freq_operand = (op == OP_MUL_HIGH) ? high_ff : band_ff;

   // Products are floored by an arithmetic shift.
   assign notch_sum = SUM_BITS'(x_ff) - SUM_BITS'(pq_ff >>> COEF_FRAC);
   assign low_sum   = SUM_BITS'(low_ff) + SUM_BITS'(pf_ff >>> COEF_FRAC);
   assign band_sum  = SUM_BITS'(band_ff) + SUM_BITS'(pf_ff >>> COEF_FRAC);
   assign high_sum  = SUM_BITS'(notch_ff) - SUM_BITS'(low_ff);

   always_comb begin
      unique case (cfg.mode)
         MODE_LOW:   sel = SEL_BITS'(low_ff);
         MODE_HIGH:  sel = SEL_BITS'(high_ff);
         MODE_BAND:  sel = SEL_BITS'(band_ff);
         MODE_NOTCH: sel = SEL_BITS'(notch_ff);
         MODE_PEAK:  sel = SEL_BITS'(low_ff) - SEL_BITS'(high_ff);
         default:    sel = '0;
      endcase
   end

   assign out_value = chan_ok_ff ? half_sat_sample(sel) : '0;

   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            x_ff       <= req_sample_in;
            chan_ff    <= req_chan;
            idx_ff     <= req_idx;
            chan_ok_ff <= req_ok;
            low_ff     <= low_mem_ff[req_idx];
            band_ff    <= band_mem_ff[req_idx];
         end
         OP_MUL_BAND: begin
            pq_ff <= DAMP_PROD_BITS'(cfg.damp * band_ff);
            pf_ff <= FREQ_PROD_BITS'(freq_s * freq_operand);
         end
         OP_UPD_LN: begin
            notch_ff <= sat_state(notch_sum);
            low_ff   <= sat_state(low_sum);
         end
         OP_CALC_HIGH: high_ff <= sat_state(high_sum);
         OP_MUL_HIGH:  pf_ff   <= FREQ_PROD_BITS'(freq_s * freq_operand);
         OP_UPD_BAND:  band_ff <= sat_state(band_sum);
         OP_FINISH: begin
            out_sample_ff <= out_value;
            out_chan_ff   <= chan_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            low_mem_ff[i]  <= '0;
            band_mem_ff[i] <= '0;
         end
      end else if (op == OP_FINISH && chan_ok_ff) begin
         low_mem_ff[idx_ff]  <= low_ff;
         band_mem_ff[idx_ff] <= band_ff;
      end
   end

   assign rsp_sample_out = out_sample_ff;
   assign rsp_chan_out   = out_chan_ff;

endmodule

@@ hdl/state_variable_filter_multichannel.sv @@
// Multichannel state variable filter with 2x oversampling.
// Input channel (req_): a signed Q1.23 sample and a channel number. The
// sample runs two filter passes on that channel's lowpass and bandpass
// integrators, which are written back when the item completes.
// Result channel (rsp_): the selected response (lowpass, highpass, bandpass,
// notch or peak, chosen by the mode register), halved and saturated to
// 24 bits, together with the channel number.
// Configuration (csr_): mode, frequency and damping coefficients, written by
// the user through a plain write port while the block is idle (not enforced).
// Timing: the controller handles one item at once and takes a new item
// only after the current one has finished. One shared pair of multipliers
// serves both passes: each pass steps through the band multiply, the lowpass
// and notch update, the highpass sum, the highpass multiply and the bandpass
// update, with the saturating adds between the two dependent multiply steps.
// Reset clears all integrators and loads the default coefficients.
// If the receiver stalls, the result is held in the output register and a
// new input transfer can still be taken; the following result then waits
// until the held one has been transferred.
module state_variable_filter_multichannel
   import svfm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic [CHAN_BITS-1:0]          req_chan,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [CHAN_BITS-1:0]          rsp_chan_out,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type cfg;
   op_type  op;

   // Configuration registers.
   svfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: steps the datapath through the two passes and owns both
   // handshakes.
   svfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .op        (op)
   );

   // Multipliers, saturating adders, integrator storage and output register.
   svfm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .op             (op),
      .req_sample_in  (req_sample_in),
      .req_chan       (req_chan),
      .rsp_sample_out (rsp_sample_out),
      .rsp_chan_out   (rsp_chan_out)
   );

endmodule

@@ hdl/svfm_checker.sv @@
module svfm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // After an input transfer the block is busy with that item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

   // A new result only appears at the end of an item's processing.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in flight");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind state_variable_filter_multichannel svfm_checker u_checker (.*);
